>>> rtl/core/fisdl_pkg.sv
// Shared sizes, command codes and status codes for the push-front list.
package fisdl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam int CMD_W    = 2;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [CMD_W-1:0]           t_cmd;
    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic [STATUS_W-1:0]        t_status;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_SEARCH = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_ABSENT = 2'd1;
    localparam t_status ST_FULL   = 2'd2;

endpackage

>>> rtl/core/front_insert_search_delete_list.sv
// Bounded push-front list of 32-bit signed values with search and delete.
//
// The list lives in a single memory used as a ring: a head pointer marks the
// front, so an insert writes one entry and moves the head. A search or delete
// walks the list from the front with one compare unit, reading each entry
// from memory and then comparing it, stopping at the first match. A delete
// then closes the gap by moving every later entry forward, reading each one
// and then writing it one place ahead. Each command passes through accept,
// setup and hand-off; insert, the unused command and a search or delete on
// an empty list need nothing more, and a search for an absent value walks
// all entries. One word is in work at a time; a finished result waits in
// the output register while the next word is taken, and a result still
// waiting there holds the block in its done state until it is taken.
module front_insert_search_delete_list (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  fisdl_pkg::t_cmd             i_cmd,
    input  fisdl_pkg::t_word            i_item_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [fisdl_pkg::POS_W-1:0] o_match_position,
    output fisdl_pkg::t_status          o_status,
    output logic [fisdl_pkg::COUNT_W-1:0] o_entry_count
);
    import fisdl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_SRD  = 3'd4;
    localparam logic [2:0] S_SWR  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state, n_state;
    t_idx       r_head, n_head;
    t_cnt       r_count, n_count;
    t_idx       r_pos, n_pos;
    t_cmd       r_cmd;
    t_word      r_val;
    logic       r_res_found, n_res_found;
    t_idx       r_res_pos, n_res_pos;
    t_status    r_res_status, n_res_status;

    logic                 r_out_valid, n_out_valid;
    logic                 r_found;
    logic [POS_W-1:0]     r_match_position;
    t_status              r_status;
    logic [COUNT_W-1:0]   r_entry_count;

    t_word r_mem [LIST_DEPTH];
    t_word r_rd_data;
    t_idx  w_raddr, w_waddr;
    t_word w_wdata;
    logic  w_we;
    logic  w_in_acc, w_load_out;

    function automatic t_idx f_addr(input t_idx head, input t_idx pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (IDX_W+1)'(LIST_DEPTH)) begin
            sum = sum - (IDX_W+1)'(LIST_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_pos        = r_pos;
        n_res_found  = r_res_found;
        n_res_pos    = r_res_pos;
        n_res_status = r_res_status;
        w_raddr      = f_addr(r_head, r_pos);
        w_waddr      = f_addr(r_head, r_pos);
        w_wdata      = r_rd_data;
        w_we         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state      = S_EXEC;
                    n_pos        = '0;
                    n_res_found  = 1'b0;
                    n_res_pos    = '0;
                    n_res_status = ST_OK;
                end
            end
            S_EXEC: begin
                priority if (r_cmd == CMD_INSERT) begin
                    n_state = S_DONE;
                    if (r_count == CNT_W'(LIST_DEPTH)) begin
                        n_res_status = ST_FULL;
                    end else begin
                        n_head  = (r_head == '0) ? IDX_W'(LIST_DEPTH - 1) : r_head - 1'b1;
                        w_waddr = n_head;
                        w_wdata = r_val;
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end else if (r_cmd == CMD_SEARCH || r_cmd == CMD_DELETE) begin
                    if (r_count == '0) begin
                        n_res_status = ST_ABSENT;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rd_data == r_val) begin
                    n_res_found = 1'b1;
                    n_res_pos   = r_pos;
                    if (r_cmd == CMD_DELETE) begin
                        if (CNT_W'(r_pos) + CNT_W'(1) == r_count) begin
                            n_count = r_count - 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SRD;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (CNT_W'(r_pos) + CNT_W'(1) == r_count) begin
                    n_res_status = ST_ABSENT;
                    n_state      = S_DONE;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_RD;
                end
            end
            S_SRD: begin
                w_raddr = f_addr(r_head, r_pos + 1'b1);
                n_state = S_SWR;
            end
            S_SWR: begin
                w_we = 1'b1;
                if (CNT_W'(r_pos) + CNT_W'(2) == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_res_found  <= n_res_found;
        r_res_pos    <= n_res_pos;
        r_res_status <= n_res_status;
        if (w_in_acc) begin
            r_cmd <= i_cmd;
            r_val <= i_item_value;
        end
        if (w_load_out) begin
            r_found          <= r_res_found;
            r_match_position <= POS_W'(r_res_pos);
            r_status         <= r_res_status;
            r_entry_count    <= COUNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_match_position = r_match_position;
    assign o_status         = r_status;
    assign o_entry_count    = r_entry_count;

endmodule

>>> rtl/core/fisdl_chk.sv
// Port-level checks for the push-front list, bound to the top level.
module fisdl_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic                          o_found,
    input  logic [fisdl_pkg::POS_W-1:0]   o_match_position,
    input  fisdl_pkg::t_status            o_status,
    input  logic [fisdl_pkg::COUNT_W-1:0] o_entry_count
);
    import fisdl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_match_position) && $stable(o_status) && $stable(o_entry_count))
        else $error("result word changed while stalled");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_count == COUNT_W'(LIST_DEPTH) && !o_found)
        else $error("full status without a full list");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == ST_OK)
        else $error("match reported with error status");

    a_absent_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_ABSENT |-> !o_found && o_match_position == '0)
        else $error("absent value with non-zero position");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken during a command");

endmodule

bind front_insert_search_delete_list fisdl_chk u_fisdl_chk (.*);
